/* rtl/core/kwb_pkg.sv */
`default_nettype none
package kwb_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int STAGE_WIDTH  = SAMPLE_WIDTH + 4;
  localparam int DIGIT        = 4;
  localparam int NUM_DIGITS   = (STAGE_WIDTH + DIGIT - 1) / DIGIT;
  localparam int PAD_WIDTH    = NUM_DIGITS * DIGIT;
  localparam int DIG_W        = $clog2(NUM_DIGITS);
  localparam int NUM_TERMS    = 5;
  localparam int TERM_W       = 3;
  localparam int TABLE_FRAC   = 30;

  localparam logic REG_RATE_SELECT = 1'b0;

  // [rate][stage][term]: b0, b1, b2, a1, a2 in Q.30; stage 0 shelf, stage 1 high-pass
  localparam longint COEF_Q30 [2][2][NUM_TERMS] = '{
    '{ '{64'sd1648327767, -64'sd2890186776, 64'sd1286764483,
         -64'sd1815331593, 64'sd786495243},
       '{64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
         -64'sd2136797184, 64'sd1063081984} },
    '{ '{64'sd1648327767, -64'sd2890186776, 64'sd1286764483,
         -64'sd1786336077, 64'sd764921422},
       '{64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
         -64'sd2135854679, 64'sd1062136671} }
  };

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           first;
    logic                           last_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           last_out;
  } out_t;

  typedef struct packed {
    logic dig_en;
    logic first_dig;
    logic acc_clr;
    logic acc_add;
    logic fin;
  } mac_ctl_t;

  // round a Q.30 coefficient to frac bits (half up), negated for feedback terms
  function automatic longint round_coef(input longint v, input logic neg, input int frac);
    longint r;
    int     sh;
    sh = TABLE_FRAC - frac;
    if (sh == 0) begin
      r = v;
    end else begin
      r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    end
    return neg ? -r : r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/kwb_mac.sv */
`default_nettype none
module kwb_mac import kwb_pkg::*; #(
  parameter int CW   = 31,
  parameter int FRAC = 28
) (
  input  wire  logic                          clk,
  input  wire  mac_ctl_t                      ctl,
  input  wire  logic signed [PAD_WIDTH-1:0]   operand,
  input  wire  logic signed [CW-1:0]          coef,
  output logic signed [STAGE_WIDTH-1:0]       stage_val
);

  localparam int PRW  = CW + PAD_WIDTH;
  localparam int ACCW = PRW + 3;
  localparam int SHW  = ACCW - FRAC;
  localparam logic [ACCW-1:0] HALF = {{(ACCW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic        [PAD_WIDTH-1:0] sr_r, sr_nxt;
  logic signed [PRW-1:0]       p_r, p_nxt;
  logic signed [ACCW-1:0]      acc_r, acc_nxt;

  logic        [PAD_WIDTH-1:0] src;
  logic        [DIGIT-1:0]     dig;
  logic signed [DIGIT:0]       dig_s;
  logic signed [CW+DIGIT:0]    pp;
  logic signed [SHW-1:0]       shv;
  logic        [SHW-STAGE_WIDTH:0] hi;
  logic                        in_range;

  // operand enters MSB digit first; the first digit carries the sign
  assign src   = ctl.first_dig ? operand : sr_r;
  assign dig   = src[PAD_WIDTH-1 -: DIGIT];
  assign dig_s = ctl.first_dig ? {dig[DIGIT-1], dig} : {1'b0, dig};
  assign pp    = coef * dig_s;

  always_comb begin
    sr_nxt  = src << DIGIT;
    p_nxt   = (ctl.first_dig ? '0 : (p_r <<< DIGIT)) + PRW'(pp);
    acc_nxt = acc_r;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_add || ctl.fin) begin
      acc_nxt = acc_r + ACCW'(p_r) + (ctl.fin ? HALF : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dig_en) begin
      sr_r <= sr_nxt;
      p_r  <= p_nxt;
    end
    acc_r <= acc_nxt;
  end

  // drop fraction, saturate to stage width
  assign shv      = acc_r[ACCW-1:FRAC];
  assign hi       = shv[SHW-1:STAGE_WIDTH-1];
  assign in_range = (&hi) | ~(|hi);
  assign stage_val = in_range ? shv[STAGE_WIDTH-1:0]
                              : {shv[SHW-1], {(STAGE_WIDTH-1){~shv[SHW-1]}}};

endmodule
`default_nettype wire

/* rtl/core/k_weighting_biquad_cascade.sv */
`default_nettype none
// channel  | ports                                   | direction
// in       | in_valid, in_stall, in_data (in_t)      | sample request into the block
// out      | out_valid, out_stall, out_data (out_t)  | filtered sample out of the block
// cfg      | psel, penable, pwrite, paddr, pwdata,   | register access, rate_select at 0x0
//          | prdata, pready                          |
//
// each sample runs through both stages in turn: each stage runs five products through one
// 4-bit digit-serial multiplier, then an add step and a saturate step
// the input stalls from acceptance until the result is written to the output register
// the result waits in the output register under out_stall; a finished sample holds in the
// saturate step until the output register is free
// rst_n is synchronous: clears control, histories and rate_select
module k_weighting_biquad_cascade import kwb_pkg::*; #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  in_t         in_data,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output out_t              out_data,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [2:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = COEF_FRAC_BITS + 3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_SAT  = 4'b1000
  } state_t;

  state_t                          st_r, st_nxt;
  logic                            stage_r, stage_nxt;
  logic        [TERM_W-1:0]        term_r, term_nxt;
  logic        [DIG_W-1:0]         dig_r, dig_nxt;
  logic                            rate_r;

  logic signed [SAMPLE_WIDTH-1:0]  x_r, x_nxt;
  logic                            last_r, last_nxt;
  logic signed [SAMPLE_WIDTH-1:0]  sin1_r, sin1_nxt, sin2_r, sin2_nxt;
  logic signed [STAGE_WIDTH-1:0]   sout1_r, sout1_nxt, sout2_r, sout2_nxt;
  logic signed [STAGE_WIDTH-1:0]   pout1_r, pout1_nxt, pout2_r, pout2_nxt;
  logic signed [STAGE_WIDTH-1:0]   s0_r, s0_nxt;
  logic                            out_valid_r, out_valid_nxt;
  out_t                            out_r, out_nxt;

  logic                            in_acc, out_free, cfg_wr;
  mac_ctl_t                        ctl;
  logic signed [PAD_WIDTH-1:0]     operand;
  logic signed [CW-1:0]            coef;
  logic signed [STAGE_WIDTH-1:0]   stage_val;
  logic        [STAGE_WIDTH-SAMPLE_WIDTH:0] ohi;
  logic signed [SAMPLE_WIDTH-1:0]  sample_sat;

  logic signed [CW-1:0] coef_tab [2][2][NUM_TERMS];

  for (genvar r = 0; r < 2; r++) begin : g_rate
    for (genvar s = 0; s < 2; s++) begin : g_stage
      for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
        assign coef_tab[r][s][t] =
          CW'(round_coef(COEF_Q30[r][s][t], (t >= 3), COEF_FRAC_BITS));
      end
    end
  end

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RATE_SELECT) ? {31'b0, rate_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_RATE_SELECT) begin
      rate_r <= pwdata[0];
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // operand select per stage and term
  always_comb begin
    operand = '0;
    if (!stage_r) begin
      case (term_r)
        3'd0:    operand = PAD_WIDTH'(x_r);
        3'd1:    operand = PAD_WIDTH'(sin1_r);
        3'd2:    operand = PAD_WIDTH'(sin2_r);
        3'd3:    operand = PAD_WIDTH'(sout1_r);
        3'd4:    operand = PAD_WIDTH'(sout2_r);
        default: operand = '0;
      endcase
    end else begin
      case (term_r)
        3'd0:    operand = PAD_WIDTH'(s0_r);
        3'd1:    operand = PAD_WIDTH'(sout1_r);
        3'd2:    operand = PAD_WIDTH'(sout2_r);
        3'd3:    operand = PAD_WIDTH'(pout1_r);
        3'd4:    operand = PAD_WIDTH'(pout2_r);
        default: operand = '0;
      endcase
    end
  end

  assign coef = coef_tab[rate_r][stage_r][term_r];

  always_comb begin
    ctl           = '0;
    ctl.dig_en    = (st_r == ST_MAC);
    ctl.first_dig = (st_r == ST_MAC) && (dig_r == '0);
    ctl.acc_clr   = ctl.first_dig && (term_r == '0);
    ctl.acc_add   = ctl.first_dig && (term_r != '0);
    ctl.fin       = (st_r == ST_ADD);
  end

  kwb_mac #(
    .CW   (CW),
    .FRAC (COEF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .ctl       (ctl),
    .operand   (operand),
    .coef      (coef),
    .stage_val (stage_val)
  );

  // output saturation from stage width to sample width
  assign ohi        = stage_val[STAGE_WIDTH-1:SAMPLE_WIDTH-1];
  assign sample_sat = ((&ohi) | ~(|ohi)) ? stage_val[SAMPLE_WIDTH-1:0]
                    : {stage_val[STAGE_WIDTH-1], {(SAMPLE_WIDTH-1){~stage_val[STAGE_WIDTH-1]}}};

  always_comb begin
    st_nxt        = st_r;
    stage_nxt     = stage_r;
    term_nxt      = term_r;
    dig_nxt       = dig_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    sin1_nxt      = sin1_r;
    sin2_nxt      = sin2_r;
    sout1_nxt     = sout1_r;
    sout2_nxt     = sout2_r;
    pout1_nxt     = pout1_r;
    pout2_nxt     = pout2_r;
    s0_nxt        = s0_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt     = in_data.sample_in;
          last_nxt  = in_data.last_in;
          stage_nxt = 1'b0;
          term_nxt  = '0;
          dig_nxt   = '0;
          st_nxt    = ST_MAC;
          // new buffer starts from rest
          if (in_data.first) begin
            sin1_nxt  = '0;
            sin2_nxt  = '0;
            sout1_nxt = '0;
            sout2_nxt = '0;
            pout1_nxt = '0;
            pout2_nxt = '0;
          end
        end
      end
      ST_MAC: begin
        if (dig_r == DIG_W'(NUM_DIGITS - 1)) begin
          dig_nxt = '0;
          if (term_r == TERM_W'(NUM_TERMS - 1)) begin
            st_nxt = ST_ADD;
          end else begin
            term_nxt = term_r + 1'b1;
          end
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      ST_ADD: begin
        st_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (!stage_r) begin
          s0_nxt    = stage_val;
          stage_nxt = 1'b1;
          term_nxt  = '0;
          dig_nxt   = '0;
          st_nxt    = ST_MAC;
        end else if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.sample_out = sample_sat;
          out_nxt.last_out   = last_r;
          sin2_nxt  = sin1_r;
          sin1_nxt  = x_r;
          sout2_nxt = sout1_r;
          sout1_nxt = s0_r;
          pout2_nxt = pout1_r;
          pout1_nxt = stage_val;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      stage_r     <= 1'b0;
      term_r      <= '0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
      sin1_r      <= '0;
      sin2_r      <= '0;
      sout1_r     <= '0;
      sout2_r     <= '0;
      pout1_r     <= '0;
      pout2_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      stage_r     <= stage_nxt;
      term_r      <= term_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
      sin1_r      <= sin1_nxt;
      sin2_r      <= sin2_nxt;
      sout1_r     <= sout1_nxt;
      sout2_r     <= sout2_nxt;
      pout1_r     <= pout1_nxt;
      pout2_r     <= pout2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    last_r <= last_nxt;
    s0_r   <= s0_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  // an accepted request keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a request");

  // term counter stays within the five products of a stage
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    term_r <= TERM_W'(NUM_TERMS - 1))
    else $error("term counter out of range");

  // a result only appears from the saturate step of the second stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == ST_SAT) && $past(stage_r))
    else $error("result written outside the final saturate step");
`endif

endmodule
`default_nettype wire
